### rtl/core/spf_pkg.sv
// Shared types, codes and frame/CRC functions for the servo packet framer.
`default_nettype none
package spf_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       cmd_t;

  // Input opcodes.
  localparam logic [2:0] OP_PING   = 3'd0;
  localparam logic [2:0] OP_TORQUE = 3'd1;
  localparam logic [2:0] OP_GOAL   = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_RX     = 3'd4;

  // Command codes as held by the framer.
  localparam cmd_t CMD_PING   = 2'd0;
  localparam cmd_t CMD_TORQUE = 2'd1;
  localparam cmd_t CMD_GOAL   = 2'd2;
  localparam cmd_t CMD_READ   = 2'd3;

  // Pending response codes.
  localparam logic [7:0] PEND_PING   = 8'd1;
  localparam logic [7:0] PEND_TORQUE = 8'd3;
  localparam logic [7:0] PEND_GOAL   = 8'd4;
  localparam logic [7:0] PEND_READ   = 8'd6;
  localparam logic [7:0] TORQUE_FAIL = 8'd99;

  // Frame constants.
  localparam logic [7:0] HDR_SYNC   = 8'hFF;
  localparam logic [7:0] HDR_MARK   = 8'hFD;
  localparam logic [7:0] INS_PING   = 8'h01;
  localparam logic [7:0] INS_READ   = 8'h02;
  localparam logic [7:0] INS_WRITE  = 8'h03;
  localparam logic [7:0] ADDR_TORQ  = 8'h40;
  localparam logic [7:0] ADDR_GOAL  = 8'h74;
  localparam logic [7:0] ADDR_POS   = 8'h84;
  localparam logic [7:0] READ_LEN   = 8'h04;
  localparam logic [15:0] CRC_POLY  = 16'h8005;

  // Received byte positions.
  localparam idx_t RX_STATUS  = idx_t'(8);
  localparam idx_t RX_POS0    = idx_t'(9);
  localparam idx_t RX_POS1    = idx_t'(10);
  localparam idx_t RX_POS2    = idx_t'(11);
  localparam idx_t RX_POS3    = idx_t'(12);
  localparam idx_t RX_CRC_LO  = idx_t'(13);
  localparam idx_t RX_CRC_HI  = idx_t'(14);
  localparam idx_t IDX_LAST   = idx_t'(FRAME_BYTES - 1);

  typedef struct packed {
    logic        cmd_take;
    logic        rx_take;
    cmd_t        cmd;
    logic [7:0]  torque;
    logic [7:0]  rx_byte;
    logic        rx_first;
  } spf_evt_t;

  typedef struct packed {
    logic [7:0]  pending;
    logic        error;
    logic [7:0]  torque;
    logic [31:0] position;
  } spf_status_t;

  function automatic logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // Number of frame bytes covered by the CRC.
  function automatic idx_t frame_len(cmd_t cmd);
    idx_t n;
    unique case (cmd)
      CMD_PING:   n = idx_t'(8);
      CMD_TORQUE: n = idx_t'(11);
      CMD_GOAL:   n = idx_t'(14);
      CMD_READ:   n = idx_t'(12);
    endcase
    return n;
  endfunction

  function automatic logic [7:0] frame_data(cmd_t cmd, idx_t k, logic [7:0] id,
                                            logic [7:0] torque, logic [31:0] pos);
    logic [7:0] b;
    b = 8'h00;
    unique case (k)
      idx_t'(0), idx_t'(1): b = HDR_SYNC;
      idx_t'(2): b = HDR_MARK;
      idx_t'(4): b = id;
      idx_t'(5): begin
        unique case (cmd)
          CMD_PING:   b = 8'h03;
          CMD_TORQUE: b = 8'h06;
          CMD_GOAL:   b = 8'h09;
          CMD_READ:   b = 8'h07;
        endcase
      end
      idx_t'(7): begin
        unique case (cmd)
          CMD_PING:   b = INS_PING;
          CMD_TORQUE: b = INS_WRITE;
          CMD_GOAL:   b = INS_WRITE;
          CMD_READ:   b = INS_READ;
        endcase
      end
      idx_t'(8): begin
        unique case (cmd)
          CMD_PING:   b = 8'h00;
          CMD_TORQUE: b = ADDR_TORQ;
          CMD_GOAL:   b = ADDR_GOAL;
          CMD_READ:   b = ADDR_POS;
        endcase
      end
      idx_t'(10): begin
        unique case (cmd)
          CMD_PING:   b = 8'h00;
          CMD_TORQUE: b = torque;
          CMD_GOAL:   b = pos[7:0];
          CMD_READ:   b = READ_LEN;
        endcase
      end
      idx_t'(11): b = (cmd == CMD_GOAL) ? pos[15:8]  : 8'h00;
      idx_t'(12): b = (cmd == CMD_GOAL) ? pos[23:16] : 8'h00;
      idx_t'(13): b = (cmd == CMD_GOAL) ? pos[31:24] : 8'h00;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### rtl/core/spf_if.sv
// Handshake channel interfaces: command requests, results and configuration writes.
`default_nettype none
interface spf_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  torque_value;
  logic [31:0] goal_position;
  logic [7:0]  rx_byte;
  logic        rx_first;
  modport source (output valid, opcode, torque_value, goal_position, rx_byte, rx_first,
                  input ready);
  modport sink   (input valid, opcode, torque_value, goal_position, rx_byte, rx_first,
                  output ready);
endinterface

interface spf_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [7:0]  pending_code;
  logic        error_flag;
  logic [7:0]  torque_state;
  logic [31:0] present_position;
  modport source (output valid, kind, tx_byte, tx_last, pending_code, error_flag,
                  torque_state, present_position, input ready);
  modport sink   (input valid, kind, tx_byte, tx_last, pending_code, error_flag,
                  torque_state, present_position, output ready);
endinterface

interface spf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/spf_status.sv
// Pending, torque, error and position state plus the status packet checker.
`default_nettype none
module spf_status (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spf_pkg::spf_evt_t   evt,
  output spf_pkg::spf_status_t     status_next
);

  logic [7:0]    pending, pending_next;
  logic [7:0]    requested_torque, requested_torque_next;
  logic [7:0]    torque_confirmed, torque_confirmed_next;
  logic          error_bit, error_bit_next;
  logic [31:0]   position_reg, position_reg_next;
  spf_pkg::idx_t rx_index, rx_index_next;
  logic [15:0]   rx_crc, rx_crc_next;
  logic [7:0]    rx_status, rx_status_next;
  logic [31:0]   rx_payload, rx_payload_next;
  logic [7:0]    rx_crc_low, rx_crc_low_next;
  logic          rx_full, rx_full_next;
  logic          rx_armed, rx_armed_next;

  spf_pkg::idx_t idx;
  logic          full_w;
  logic          armed_w;
  logic [15:0]   crc_base;

  assign idx      = evt.rx_first ? '0 : rx_index;
  assign full_w   = evt.rx_first ? 1'b0 : rx_full;
  assign armed_w  = evt.rx_first ? 1'b0 : rx_armed;
  assign crc_base = (evt.rx_first || idx == '0) ? 16'h0000 : rx_crc;

  always_comb begin
    pending_next          = pending;
    requested_torque_next = requested_torque;
    torque_confirmed_next = torque_confirmed;
    error_bit_next        = error_bit;
    position_reg_next     = position_reg;
    rx_index_next         = rx_index;
    rx_crc_next           = rx_crc;
    rx_status_next        = rx_status;
    rx_payload_next       = rx_payload;
    rx_crc_low_next       = rx_crc_low;
    rx_full_next          = rx_full;
    rx_armed_next         = rx_armed;
    if (evt.cmd_take) begin
      rx_armed_next = 1'b0;
      unique case (evt.cmd)
        spf_pkg::CMD_PING:   pending_next = spf_pkg::PEND_PING;
        spf_pkg::CMD_TORQUE: begin
          requested_torque_next = evt.torque;
          pending_next          = spf_pkg::PEND_TORQUE;
        end
        spf_pkg::CMD_GOAL:   pending_next = spf_pkg::PEND_GOAL;
        spf_pkg::CMD_READ:   pending_next = spf_pkg::PEND_READ;
      endcase
    end else if (evt.rx_take) begin
      // A marked byte restarts the packet even after the buffer filled up.
      rx_full_next  = full_w;
      rx_armed_next = armed_w;
      rx_crc_next   = evt.rx_first ? 16'h0000 : rx_crc;
      rx_index_next = idx;
      if (!full_w) begin
        rx_crc_next = (idx <= spf_pkg::RX_POS3) ? spf_pkg::crc_add(crc_base, evt.rx_byte)
                                                : crc_base;
        unique case (idx)
          spf_pkg::RX_STATUS: begin
            rx_status_next = evt.rx_byte;
            unique case (pending)
              spf_pkg::PEND_PING: pending_next = evt.rx_byte;
              spf_pkg::PEND_TORQUE: begin
                pending_next          = evt.rx_byte;
                torque_confirmed_next = (evt.rx_byte == 8'h00) ? requested_torque
                                                               : spf_pkg::TORQUE_FAIL;
              end
              spf_pkg::PEND_GOAL: begin
                pending_next   = evt.rx_byte;
                error_bit_next = (evt.rx_byte != 8'h00);
              end
              spf_pkg::PEND_READ: begin
                pending_next  = evt.rx_byte;
                rx_armed_next = 1'b1;
              end
              default: ;
            endcase
          end
          spf_pkg::RX_POS0:   rx_payload_next[7:0]   = evt.rx_byte;
          spf_pkg::RX_POS1:   rx_payload_next[15:8]  = evt.rx_byte;
          spf_pkg::RX_POS2:   rx_payload_next[23:16] = evt.rx_byte;
          spf_pkg::RX_POS3:   rx_payload_next[31:24] = evt.rx_byte;
          spf_pkg::RX_CRC_LO: rx_crc_low_next        = evt.rx_byte;
          spf_pkg::RX_CRC_HI: begin
            if (armed_w) begin
              if (rx_crc_low == crc_base[7:0] && evt.rx_byte == crc_base[15:8]) begin
                if (rx_status == 8'h00) begin
                  position_reg_next = rx_payload;
                  error_bit_next    = 1'b0;
                end
              end else begin
                error_bit_next = 1'b1;
              end
              rx_armed_next = 1'b0;
            end
          end
          default: ;
        endcase
        if (idx == spf_pkg::IDX_LAST) begin
          rx_full_next = 1'b1;
        end else begin
          rx_index_next = idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending          <= '0;
      requested_torque <= '0;
      torque_confirmed <= '0;
      error_bit        <= 1'b0;
      position_reg     <= '0;
      rx_index         <= '0;
      rx_crc           <= '0;
      rx_status        <= '0;
      rx_payload       <= '0;
      rx_crc_low       <= '0;
      rx_full          <= 1'b0;
      rx_armed         <= 1'b0;
    end else begin
      pending          <= pending_next;
      requested_torque <= requested_torque_next;
      torque_confirmed <= torque_confirmed_next;
      error_bit        <= error_bit_next;
      position_reg     <= position_reg_next;
      rx_index         <= rx_index_next;
      rx_crc           <= rx_crc_next;
      rx_status        <= rx_status_next;
      rx_payload       <= rx_payload_next;
      rx_crc_low       <= rx_crc_low_next;
      rx_full          <= rx_full_next;
      rx_armed         <= rx_armed_next;
    end
  end

  assign status_next.pending  = pending_next;
  assign status_next.error    = error_bit_next;
  assign status_next.torque   = torque_confirmed_next;
  assign status_next.position = position_reg_next;

endmodule
`default_nettype wire

### rtl/core/spf_framer.sv
// Instruction frame sequencer: one frame byte per step with a running CRC.
`default_nettype none
module spf_framer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          step,
  input  wire spf_pkg::cmd_t cmd,
  input  wire logic [7:0]    servo_id,
  input  wire logic [7:0]    torque,
  input  wire logic [31:0]   pos,
  output logic               busy,
  output logic               emit,
  output logic [7:0]         tx_byte,
  output logic               tx_last
);

  spf_pkg::cmd_t cmd_r;
  logic [7:0]    torque_r;
  logic [31:0]   pos_r;
  spf_pkg::idx_t cnt;
  logic [15:0]   crc;

  spf_pkg::cmd_t cmd_c;
  logic [7:0]    torque_c;
  logic [31:0]   pos_c;
  spf_pkg::idx_t k;
  spf_pkg::idx_t n;
  logic [15:0]   crc_c;
  logic [7:0]    data;

  assign cmd_c    = start ? cmd : cmd_r;
  assign torque_c = start ? torque : torque_r;
  assign pos_c    = start ? pos : pos_r;
  assign k        = start ? '0 : cnt;
  assign crc_c    = start ? 16'h0000 : crc;
  assign n        = spf_pkg::frame_len(cmd_c);
  assign data     = spf_pkg::frame_data(cmd_c, k, servo_id, torque_c, pos_c);
  assign emit     = start || (busy && step);
  assign tx_last  = (k == spf_pkg::IDX_LAST);

  // The CRC goes out low byte first right after the covered bytes.
  always_comb begin
    if (k < n) begin
      tx_byte = data;
    end else if (k == n) begin
      tx_byte = crc_c[7:0];
    end else if (k == n + 1'b1) begin
      tx_byte = crc_c[15:8];
    end else begin
      tx_byte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (emit) begin
      busy <= !tx_last;
      cnt  <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r    <= cmd;
      torque_r <= torque;
      pos_r    <= pos;
    end
    if (emit) begin
      crc <= (k < n) ? spf_pkg::crc_add(crc_c, data) : crc_c;
    end
  end

endmodule
`default_nettype wire

### rtl/core/servo_packet_framer_and_status_checker_core.sv
// Top level: request holding register, framer, status checker and result register.
// The first result of a request is registered in the result register when the request is taken.
// A command gives 16 frame bytes, one per step of the framer's byte counter, each step waiting
// on a free result register; a received byte gives one result. Unused opcodes are dropped with no result.
// Reset (rst, synchronous): clears the control and status state, sets servo_id to 1, empties both registers.
`default_nettype none
module servo_packet_framer_and_status_checker_core (
  input  wire logic clk,
  input  wire logic rst,
  spf_cmd_if.sink   cmd,
  spf_res_if.source res,
  spf_cfg_if.sink   cfg
);

  logic [7:0]  servo_id;

  logic        hold_valid;
  logic [2:0]  hold_op;
  logic [7:0]  hold_torque;
  logic [31:0] hold_pos;
  logic [7:0]  hold_rx_byte;
  logic        hold_rx_first;

  logic        out_adv;
  logic        take;
  logic        start;
  logic        rx_take;

  logic        busy;
  logic        emit;
  logic [7:0]  frame_byte;
  logic        frame_last;

  spf_pkg::spf_evt_t    evt;
  spf_pkg::spf_status_t status_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id <= 8'd1;
    end else if (cfg.valid) begin
      servo_id <= cfg.data;
    end
  end

  assign out_adv   = !res.valid || res.ready;
  assign take      = hold_valid && !busy && out_adv;
  assign start     = take && (hold_op <= spf_pkg::OP_READ);
  assign rx_take   = take && (hold_op == spf_pkg::OP_RX);
  assign cmd.ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      hold_op       <= cmd.opcode;
      hold_torque   <= cmd.torque_value;
      hold_pos      <= cmd.goal_position;
      hold_rx_byte  <= cmd.rx_byte;
      hold_rx_first <= cmd.rx_first;
    end
  end

  assign evt.cmd_take = start;
  assign evt.rx_take  = rx_take;
  assign evt.cmd      = hold_op[1:0];
  assign evt.torque   = hold_torque;
  assign evt.rx_byte  = hold_rx_byte;
  assign evt.rx_first = hold_rx_first;

  spf_status u_status (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .status_next (status_next)
  );

  spf_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .step     (out_adv),
    .cmd      (hold_op[1:0]),
    .servo_id (servo_id),
    .torque   (hold_torque),
    .pos      (hold_pos),
    .busy     (busy),
    .emit     (emit),
    .tx_byte  (frame_byte),
    .tx_last  (frame_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit || rx_take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // While a frame is going out no other request is taken, so the live status is the
  // status right after the command.
  always_ff @(posedge clk) begin
    if (emit || rx_take) begin
      res.kind             <= rx_take;
      res.tx_byte          <= rx_take ? 8'h00 : frame_byte;
      res.tx_last          <= rx_take ? 1'b0 : frame_last;
      res.pending_code     <= status_next.pending;
      res.error_flag       <= status_next.error;
      res.torque_state     <= status_next.torque;
      res.present_position <= status_next.position;
    end
  end

endmodule
`default_nettype wire
